[rtl/core/assert_macros.svh]
// Assertion macros shared by the sensor front end RTL.
// Each macro expects clk and arst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/core/iracs_pkg.sv]
// Types, constants and the emitter sequence table of the IR ambient-cancel front end.
// No dependencies.
package iracs_pkg;

	localparam int CHANNELS    = 5;
	localparam int NUM_STEPS   = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic       CMD_SAMPLE  = 1'b0;
	localparam logic       CMD_TICK    = 1'b1;
	localparam logic [15:0] CLAMP_RESET = 16'd30000;
	localparam logic [18:0] SUM_MAX     = 19'h7FFFF;
	localparam logic [2:0] LAST_STEP   = 3'(NUM_STEPS - 1);

	typedef struct packed {
		logic        cmd;
		logic [11:0] sample_0;
		logic [11:0] sample_1;
		logic [11:0] sample_2;
		logic [11:0] sample_3;
		logic [11:0] sample_4;
	} in_t;

	typedef struct packed {
		logic [4:0]  emitter_mask;
		logic [15:0] level_0;
		logic [15:0] level_1;
		logic [15:0] level_2;
		logic [15:0] level_3;
		logic [15:0] level_4;
		logic [18:0] change_sum_left;
		logic [18:0] change_sum_right;
	} out_t;

	typedef logic [CHANNELS-1:0][15:0] level_arr_t;

	// One classified item on its way from the front to the back.
	typedef struct packed {
		logic       is_tick;
		logic [4:0] mask;
		level_arr_t raw;
	} entry_t;

	function automatic logic [4:0] step_mask(input logic [2:0] step);
		logic [4:0] m;
		unique case (step)
			3'd0:    m = 5'h00;
			3'd1:    m = 5'h04;
			3'd2:    m = 5'h11;
			3'd3:    m = 5'h02;
			3'd4:    m = 5'h08;
			default: m = 5'h00;
		endcase
		return m;
	endfunction

endpackage

[rtl/core/ir_ambient_cancel_sensor_front_end.sv]
// Top level of the five-channel IR ambient-cancel sensor front end.
// Depends on iracs_pkg, iracs_front, iracs_queue, iracs_back, iracs_ram.
//
// Usage:
//   item channel (item_valid / item_stall / item): cmd = sample files the five
//   converter values as dark or lit for the current emitter step and advances
//   the step; cmd = tick forms lit minus dark levels, changes and window sums.
//   result channel (result_valid / result_stall / result): one result per item,
//   in order. A sample result carries the emitter mask for the new step and
//   zero levels and sums; a tick result carries clamped levels and the outer
//   channel change sums over the last WINDOW_DEPTH ticks.
//   cfg_we / cfg_data write the clamp threshold (reset 30000); write only idle.
// Timing:
//   one item per cycle while result_stall is low; an item passes the queue,
//   the stage 1 register and the result register. Window sums move on ticks only.
//   A four-entry queue, one stage register and the result register hold up to
//   six items; when result_stall stays high the queue fills and item_stall rises.
// Reset: arst_n clears the step, stored levels, window fill and all valids; the
//   window RAM needs no clearing since unfilled slots read as zero.
module ir_ambient_cancel_sensor_front_end #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  iracs_pkg::in_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output iracs_pkg::out_t  result,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_data
);

	logic              push;
	logic              full;
	logic              pop;
	logic              head_valid;
	iracs_pkg::entry_t push_data;
	iracs_pkg::entry_t head;

	iracs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	iracs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.valid    (head_valid),
		.pop_data (head)
	);

	iracs_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

[rtl/core/iracs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iracs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/iracs_front.sv]
// Front part: accepts items, files samples as dark or lit, runs the emitter step
// sequence and forms raw levels for ticks. Depends on iracs_pkg.
module iracs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  iracs_pkg::in_t      item,
	input  logic                full,
	output logic                push,
	output iracs_pkg::entry_t   push_data
);

	logic [2:0]                            step_q;
	logic [2:0]                            step_nxt;
	logic [iracs_pkg::CHANNELS-1:0][11:0]  dark_q;
	logic [iracs_pkg::CHANNELS-1:0][11:0]  lit_q;
	logic [iracs_pkg::CHANNELS-1:0][11:0]  smp;
	logic [4:0]                            lit_sel;
	logic                                  is_tick;

	assign item_stall = full;
	assign push       = item_valid && !full;
	assign is_tick    = (item.cmd == iracs_pkg::CMD_TICK);
	assign lit_sel    = iracs_pkg::step_mask(step_q);

	assign smp[0] = item.sample_0;
	assign smp[1] = item.sample_1;
	assign smp[2] = item.sample_2;
	assign smp[3] = item.sample_3;
	assign smp[4] = item.sample_4;

	always_comb begin
		step_nxt = (step_q >= iracs_pkg::LAST_STEP) ? 3'd0 : step_q + 3'd1;
		push_data.is_tick = is_tick;
		// a tick reports the current step, a sample the step it advances to
		push_data.mask = is_tick ? lit_sel : iracs_pkg::step_mask(step_nxt);
		for (int k = 0; k < iracs_pkg::CHANNELS; k++) begin
			push_data.raw[k] = {4'd0, lit_q[k]} - {4'd0, dark_q[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			dark_q <= '0;
			lit_q  <= '0;
		end else if (push && !is_tick) begin
			for (int k = 0; k < iracs_pkg::CHANNELS; k++) begin
				if (lit_sel[k]) begin
					lit_q[k] <= smp[k];
				end else begin
					dark_q[k] <= smp[k];
				end
			end
			step_q <= step_nxt;
		end
	end

	`include "assert_macros.svh"

	`ASSERT_CLK(a_step_range, step_q <= iracs_pkg::LAST_STEP, "emitter step out of range")
	`ASSERT_CLK(a_tick_keeps_step, (push && is_tick) |=> $stable(step_q), "tick moved the step")

endmodule

[rtl/core/iracs_queue.sv]
// Short queue between the front and the back part.
// Depends on iracs_pkg.
module iracs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  iracs_pkg::entry_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output iracs_pkg::entry_t pop_data
);

	localparam logic [iracs_pkg::QPTR_W:0] DEPTH_CNT = (iracs_pkg::QPTR_W + 1)'(iracs_pkg::QUEUE_DEPTH);

	iracs_pkg::entry_t             mem_q [iracs_pkg::QUEUE_DEPTH];
	logic [iracs_pkg::QPTR_W-1:0]  wr_q;
	logic [iracs_pkg::QPTR_W-1:0]  rd_q;
	logic [iracs_pkg::QPTR_W:0]    cnt_q;

	assign full     = (cnt_q == DEPTH_CNT);
	assign valid    = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`include "assert_macros.svh"

	`ASSERT_CLK(a_cnt_bound, cnt_q <= DEPTH_CNT, "queue count above depth")
	`ASSERT_NEVER(a_push_full, push && full, "push into full queue")
	`ASSERT_NEVER(a_pop_empty, pop && !valid, "pop from empty queue")

endmodule

[rtl/core/iracs_back.sv]
// Back part: change detection, sliding-window sums, clamping and the result register.
// Depends on iracs_pkg and iracs_ram.
module iracs_back #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	input  logic              head_valid,
	input  iracs_pkg::entry_t head,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output iracs_pkg::out_t   result
);

	localparam int AW    = $clog2(WINDOW_DEPTH);
	localparam int FW    = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = (16 + AW > 19) ? 16 + AW : 19;

	logic [15:0]                 clamp_q;
	logic [15:0]                 prev_l_q;
	logic [15:0]                 prev_r_q;
	logic [15:0]                 d_l;
	logic [15:0]                 d_r;
	logic [15:0]                 chg_l;
	logic [15:0]                 chg_r;
	iracs_pkg::level_arr_t       lvl;

	logic                        valid_s1;
	logic                        tick_s1;
	logic [4:0]                  mask_s1;
	iracs_pkg::level_arr_t       lvl_s1;
	logic [15:0]                 chg_l_s1;
	logic [15:0]                 chg_r_s1;

	logic                        out_adv;
	logic                        s1_adv;
	logic                        fire;
	logic [AW-1:0]               slot_q;
	logic [AW-1:0]               slot_nxt;
	logic [FW-1:0]               fill_q;
	logic                        win_full;
	logic [31:0]                 rdata;
	logic [15:0]                 old_l;
	logic [15:0]                 old_r;
	logic [SUM_W-1:0]            sum_l_q;
	logic [SUM_W-1:0]            sum_r_q;
	logic [SUM_W-1:0]            sum_l_nxt;
	logic [SUM_W-1:0]            sum_r_nxt;
	iracs_pkg::out_t             result_q;
	logic                        result_valid_q;

	function automatic logic [18:0] sat19(input logic [SUM_W-1:0] s);
		if (s > SUM_W'(iracs_pkg::SUM_MAX)) begin
			return iracs_pkg::SUM_MAX;
		end
		return s[18:0];
	endfunction

	assign result       = result_q;
	assign result_valid = result_valid_q;
	assign out_adv      = !result_valid_q || !result_stall;
	assign s1_adv       = !valid_s1 || out_adv;
	assign pop          = head_valid && s1_adv;

	// stage 1: absolute change on the outer channels, clamp every level
	always_comb begin
		d_l   = prev_l_q - head.raw[0];
		d_r   = prev_r_q - head.raw[iracs_pkg::CHANNELS-1];
		chg_l = d_l[15] ? (~d_l + 16'd1) : d_l;
		chg_r = d_r[15] ? (~d_r + 16'd1) : d_r;
		for (int k = 0; k < iracs_pkg::CHANNELS; k++) begin
			lvl[k] = (!head.is_tick || head.raw[k] > clamp_q) ? 16'd0 : head.raw[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q  <= iracs_pkg::CLAMP_RESET;
			prev_l_q <= '0;
			prev_r_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				clamp_q <= cfg_data;
			end
			if (s1_adv) begin
				valid_s1 <= head_valid;
			end
			// keep the unclamped level as the base for the next change
			if (pop && head.is_tick) begin
				prev_l_q <= head.raw[0];
				prev_r_q <= head.raw[iracs_pkg::CHANNELS-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tick_s1  <= head.is_tick;
			mask_s1  <= head.mask;
			lvl_s1   <= lvl;
			chg_l_s1 <= chg_l;
			chg_r_s1 <= chg_r;
		end
	end

	// stage 2: window slot replace and running sums
	assign fire     = out_adv && valid_s1 && tick_s1;
	assign slot_nxt = (slot_q == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
	assign win_full = (fill_q == FW'(WINDOW_DEPTH));
	// slots not yet written since reset read as zero
	assign old_l    = win_full ? rdata[31:16] : 16'd0;
	assign old_r    = win_full ? rdata[15:0] : 16'd0;

	iracs_ram #(
		.WIDTH(32),
		.DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk  (clk),
		.we   (fire),
		.waddr(slot_q),
		.wdata({chg_l_s1, chg_r_s1}),
		.raddr(fire ? slot_nxt : slot_q),
		.rdata(rdata)
	);

	always_comb begin
		sum_l_nxt = sum_l_q - SUM_W'(old_l) + SUM_W'(chg_l_s1);
		sum_r_nxt = sum_r_q - SUM_W'(old_r) + SUM_W'(chg_r_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q         <= '0;
			fill_q         <= '0;
			sum_l_q        <= '0;
			sum_r_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (out_adv) begin
				result_valid_q <= valid_s1;
			end
			if (fire) begin
				slot_q  <= slot_nxt;
				sum_l_q <= sum_l_nxt;
				sum_r_q <= sum_r_nxt;
				if (!win_full) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			result_q.emitter_mask     <= mask_s1;
			result_q.level_0          <= lvl_s1[0];
			result_q.level_1          <= lvl_s1[1];
			result_q.level_2          <= lvl_s1[2];
			result_q.level_3          <= lvl_s1[3];
			result_q.level_4          <= lvl_s1[4];
			result_q.change_sum_left  <= tick_s1 ? sat19(sum_l_nxt) : 19'd0;
			result_q.change_sum_right <= tick_s1 ? sat19(sum_r_nxt) : 19'd0;
		end
	end

	`include "assert_macros.svh"

	`ASSERT_CLK(a_fill_bound, fill_q <= FW'(WINDOW_DEPTH), "window fill above depth")
	`ASSERT_CLK(a_slot_tracks_fill, !win_full |-> (FW'(slot_q) == fill_q),
		"window slot out of step with fill count")
	`ASSERT_CLK(a_sum_holds_idle, !$past(fire) |-> ($stable(sum_l_q) && $stable(sum_r_q)),
		"running sum moved without a tick")

endmodule
